@@ rtl/ppr_pkg.sv @@
// shared types, constants and helpers for the plane/ray query pipeline
// no dependencies; imported by ppr_divider and plane_point_ray_query
`timescale 1ns / 1ps
package ppr_pkg;

   localparam int NUM_W  = 49;   // magnitude of distance and of denominator
   localparam int DIST_W = 50;   // full-width signed distance
   localparam int SUM_W  = 66;   // exact sum of three 64-bit products
   localparam int Q_W    = 31;   // quotient bits below the saturation point
   localparam int DIV_STEPS = Q_W;
   localparam int PRE_STAGES = 6;
   localparam int LATENCY = PRE_STAGES + DIV_STEPS + 1;

   localparam logic [31:0] RST_NORMAL_X = 32'd0;
   localparam logic [31:0] RST_NORMAL_Y = 32'd65536;
   localparam logic [31:0] RST_NORMAL_Z = 32'd0;
   localparam logic [31:0] RST_OFFSET   = 32'd0;
   localparam logic [30:0] RST_EPSILON  = 31'd66;

   typedef enum logic [2:0] {
      REG_NORMAL_X = 3'd0,
      REG_NORMAL_Y = 3'd1,
      REG_NORMAL_Z = 3'd2,
      REG_OFFSET   = 3'd3,
      REG_EPSILON  = 3'd4
   } ppr_reg_type;

   localparam logic [1:0] SIDE_FRONT  = 2'd0;
   localparam logic [1:0] SIDE_BACK   = 2'd1;
   localparam logic [1:0] SIDE_WITHIN = 2'd2;

   typedef struct packed {
      logic [1:0]         side;
      logic               hit;
      logic               sat;
      logic               neg;
      logic signed [31:0] distance;
      logic signed [31:0] proj_x;
      logic signed [31:0] proj_y;
      logic signed [31:0] proj_z;
   } ppr_tag_type;

   function automatic logic signed [31:0] sat32(input logic signed [DIST_W-1:0] x);
      logic signed [DIST_W-1:0] hi;
      logic signed [DIST_W-1:0] lo;
      hi = DIST_W'(64'sd2147483647);
      lo = -DIST_W'(64'sd2147483648);
      if (x > hi)
         return 32'sh7fffffff;
      else if (x < lo)
         return 32'sh80000000;
      else
         return x[31:0];
   endfunction

endpackage

@@ rtl/ppr_divider.sv @@
// pipelined restoring divider, one quotient bit per stage, with sideband tag
// depends on ppr_pkg
`timescale 1ns / 1ps
module ppr_divider import ppr_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  ppr_tag_type        in_tag,
   input  logic [NUM_W-1:0]   in_rem,
   input  logic [Q_W-1:0]     in_low,
   input  logic [NUM_W-1:0]   in_den,
   output logic               out_valid,
   output ppr_tag_type        out_tag,
   output logic [Q_W-1:0]     out_quot
);

   logic                vld_ff [DIV_STEPS];
   ppr_tag_type         tag_ff [DIV_STEPS];
   logic [NUM_W-1:0]    rem_ff [DIV_STEPS];
   logic [Q_W-1:0]      low_ff [DIV_STEPS];
   logic [NUM_W-1:0]    den_ff [DIV_STEPS];
   logic [Q_W-1:0]      quot_ff [DIV_STEPS];

   logic [NUM_W-1:0]    rem_in [DIV_STEPS];
   logic [Q_W-1:0]      low_in [DIV_STEPS];
   logic [Q_W-1:0]      quot_in [DIV_STEPS];

   always_comb begin
      for (int k = 0; k < DIV_STEPS; k++) begin
         logic [NUM_W:0]   trial;
         logic [NUM_W-1:0] r_src;
         logic [Q_W-1:0]   l_src;
         logic [Q_W-1:0]   q_src;
         logic [NUM_W-1:0] d_src;
         if (k == 0) begin
            r_src = in_rem;
            l_src = in_low;
            q_src = '0;
            d_src = in_den;
         end else begin
            r_src = rem_ff[k-1];
            l_src = low_ff[k-1];
            q_src = quot_ff[k-1];
            d_src = den_ff[k-1];
         end
         trial = {r_src, l_src[Q_W-1]};
         if (trial >= {1'b0, d_src}) begin
            rem_in[k]  = NUM_W'(trial - {1'b0, d_src});
            quot_in[k] = {q_src[Q_W-2:0], 1'b1};
         end else begin
            rem_in[k]  = trial[NUM_W-1:0];
            quot_in[k] = {q_src[Q_W-2:0], 1'b0};
         end
         low_in[k] = {l_src[Q_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < DIV_STEPS; k++) begin
         rem_ff[k]  <= rem_in[k];
         low_ff[k]  <= low_in[k];
         quot_ff[k] <= quot_in[k];
         if (k == 0) begin
            tag_ff[k] <= in_tag;
            den_ff[k] <= in_den;
         end else begin
            tag_ff[k] <= tag_ff[k-1];
            den_ff[k] <= den_ff[k-1];
         end
      end
      if (reset) begin
         for (int k = 0; k < DIV_STEPS; k++)
            vld_ff[k] <= 1'b0;
      end else begin
         for (int k = 0; k < DIV_STEPS; k++)
            vld_ff[k] <= (k == 0) ? in_valid : vld_ff[k-1];
      end
   end

   assign out_valid = vld_ff[DIV_STEPS-1];
   assign out_tag   = tag_ff[DIV_STEPS-1];
   assign out_quot  = quot_ff[DIV_STEPS-1];

   // for a hit that did not saturate, the final remainder stays below its divisor
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      vld_ff[DIV_STEPS-1] && !tag_ff[DIV_STEPS-1].sat && tag_ff[DIV_STEPS-1].hit
      |-> rem_ff[DIV_STEPS-1] < den_ff[DIV_STEPS-1])
      else $error("divider remainder not below divisor");

   a_valid_flow: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> $past(in_valid, DIV_STEPS))
      else $error("divider output without matching input");

   a_low_drained: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> low_ff[DIV_STEPS-1] == '0)
      else $error("divider dividend bits not consumed");

endmodule

@@ rtl/plane_point_ray_query.sv @@
// plane query top level: config registers, dot products, classification,
// projection and ray parameter; depends on ppr_pkg and ppr_divider
`timescale 1ns / 1ps
// One query is accepted every clock cycle (busy is always low) and its result
// appears with rsp_valid after registers for products, sums, classification
// and projection, then the 31-stage divider that forms the ray parameter, one
// quotient bit per stage, then an output register. Results cannot be held
// off. Plane registers must be written through the csr port only while no
// transaction is in flight; the block itself does not enforce this.
module plane_point_ray_query import ppr_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [31:0] req_origin_x,
   input  logic signed [31:0] req_origin_y,
   input  logic signed [31:0] req_origin_z,
   input  logic signed [31:0] req_dir_x,
   input  logic signed [31:0] req_dir_y,
   input  logic signed [31:0] req_dir_z,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_signed_distance,
   output logic [1:0]         rsp_side,
   output logic               rsp_hit,
   output logic signed [31:0] rsp_hit_t,
   output logic signed [31:0] rsp_proj_x,
   output logic signed [31:0] rsp_proj_y,
   output logic signed [31:0] rsp_proj_z,
   input  logic               csr_we,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_wdata
);

   logic signed [31:0] normal_ff [3];
   logic signed [31:0] offset_ff;
   logic [30:0]        epsilon_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         normal_ff[0] <= RST_NORMAL_X;
         normal_ff[1] <= RST_NORMAL_Y;
         normal_ff[2] <= RST_NORMAL_Z;
         offset_ff    <= RST_OFFSET;
         epsilon_ff   <= RST_EPSILON;
      end else if (csr_we) begin
         case (csr_index)
            REG_NORMAL_X: normal_ff[0] <= csr_wdata;
            REG_NORMAL_Y: normal_ff[1] <= csr_wdata;
            REG_NORMAL_Z: normal_ff[2] <= csr_wdata;
            REG_OFFSET:   offset_ff    <= csr_wdata;
            REG_EPSILON:  epsilon_ff   <= csr_wdata[30:0];
            default: ;
         endcase
      end
   end

   assign busy = 1'b0;

   logic accept;
   assign accept = start && !busy;

   logic signed [31:0] org_in [3];
   logic signed [31:0] dir_in [3];
   assign org_in[0] = req_origin_x;
   assign org_in[1] = req_origin_y;
   assign org_in[2] = req_origin_z;
   assign dir_in[0] = req_dir_x;
   assign dir_in[1] = req_dir_y;
   assign dir_in[2] = req_dir_z;

   // stage 1: products
   logic               v1_ff;
   logic signed [63:0] po_ff [3];
   logic signed [63:0] pd_ff [3];
   logic signed [31:0] o1_ff [3];
   // stage 2: exact sums
   logic               v2_ff;
   logic signed [SUM_W-1:0] so_ff;
   logic signed [SUM_W-1:0] sd_ff;
   logic signed [31:0] o2_ff [3];
   // stage 3: floored dots
   logic               v3_ff;
   logic signed [DIST_W-1:0] d_ff;
   logic signed [NUM_W-1:0]  den_ff;
   logic signed [31:0] o3_ff [3];
   // stage 4: classify and magnitudes
   logic               v4_ff;
   logic signed [31:0] dist4_ff;
   logic [1:0]         side4_ff;
   logic               neg4_ff;
   logic [NUM_W-1:0]   num4_ff;
   logic [NUM_W-1:0]   mden4_ff;
   logic signed [31:0] o4_ff [3];
   // stage 5: hit test and projection products
   logic               v5_ff;
   logic signed [31:0] dist5_ff;
   logic [1:0]         side5_ff;
   logic               neg5_ff;
   logic               hit5_ff;
   logic               sat5_ff;
   logic [NUM_W-1:0]   num5_ff;
   logic [NUM_W-1:0]   mden5_ff;
   logic signed [63:0] pn_ff [3];
   logic signed [31:0] o5_ff [3];
   // stage 6: projection and divider setup
   logic               v6_ff;
   ppr_tag_type        tag6_ff;
   logic [NUM_W-1:0]   rem6_ff;
   logic [Q_W-1:0]     low6_ff;
   logic [NUM_W-1:0]   mden6_ff;

   logic signed [DIST_W-1:0] d_in;
   logic signed [NUM_W-1:0]  den_in;
   logic signed [SUM_W-1:0]  so_sh;
   logic signed [SUM_W-1:0]  sd_sh;
   logic signed [DIST_W-1:0] d_abs;
   logic signed [DIST_W-1:0] den_abs;
   logic signed [DIST_W-1:0] eps_ext;
   logic [1:0]               side_in;
   logic signed [31:0]       proj_in [3];

   always_comb begin
      so_sh   = so_ff >>> 16;
      sd_sh   = sd_ff >>> 16;
      d_in    = DIST_W'(so_sh) + DIST_W'(offset_ff);
      den_in  = sd_sh[NUM_W-1:0];
      d_abs   = d_ff[DIST_W-1] ? -d_ff : d_ff;
      den_abs = den_ff[NUM_W-1] ? -DIST_W'(den_ff) : DIST_W'(den_ff);
      eps_ext = DIST_W'({1'b0, epsilon_ff});
      if (d_ff > eps_ext)
         side_in = SIDE_FRONT;
      else if (d_ff < -eps_ext)
         side_in = SIDE_BACK;
      else
         side_in = SIDE_WITHIN;
      for (int i = 0; i < 3; i++) begin
         logic signed [63:0] pn_sh;
         pn_sh = pn_ff[i] >>> 16;
         proj_in[i] = sat32(DIST_W'(o5_ff[i]) - DIST_W'($signed(pn_sh[47:0])));
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         po_ff[i] <= org_in[i] * normal_ff[i];
         pd_ff[i] <= dir_in[i] * normal_ff[i];
         o1_ff[i] <= org_in[i];
         o2_ff[i] <= o1_ff[i];
         o3_ff[i] <= o2_ff[i];
         o4_ff[i] <= o3_ff[i];
         o5_ff[i] <= o4_ff[i];
         pn_ff[i] <= dist4_ff * normal_ff[i];
      end
      so_ff <= SUM_W'(po_ff[0]) + SUM_W'(po_ff[1]) + SUM_W'(po_ff[2]);
      sd_ff <= SUM_W'(pd_ff[0]) + SUM_W'(pd_ff[1]) + SUM_W'(pd_ff[2]);
      d_ff   <= d_in;
      den_ff <= den_in;
      dist4_ff <= sat32(d_ff);
      side4_ff <= side_in;
      neg4_ff  <= (d_ff > 0 && den_ff > 0) || (d_ff < 0 && den_ff < 0);
      num4_ff  <= d_abs[NUM_W-1:0];
      mden4_ff <= den_abs[NUM_W-1:0];
      dist5_ff <= dist4_ff;
      side5_ff <= side4_ff;
      neg5_ff  <= neg4_ff;
      hit5_ff  <= (mden4_ff != '0) && (mden4_ff >= NUM_W'(epsilon_ff));
      sat5_ff  <= NUM_W'(num4_ff[NUM_W-1:15]) >= mden4_ff;
      num5_ff  <= num4_ff;
      mden5_ff <= mden4_ff;
      tag6_ff.side     <= side5_ff;
      tag6_ff.hit      <= hit5_ff;
      tag6_ff.sat      <= sat5_ff;
      tag6_ff.neg      <= neg5_ff;
      tag6_ff.distance <= dist5_ff;
      tag6_ff.proj_x   <= proj_in[0];
      tag6_ff.proj_y   <= proj_in[1];
      tag6_ff.proj_z   <= proj_in[2];
      rem6_ff  <= NUM_W'(num5_ff[NUM_W-1:15]);
      low6_ff  <= {num5_ff[14:0], 16'b0};
      mden6_ff <= mden5_ff;
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else begin
         v1_ff <= accept;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
      end
   end

   logic           dv_valid;
   ppr_tag_type    dv_tag;
   logic [Q_W-1:0] dv_quot;

   ppr_divider u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v6_ff),
      .in_tag    (tag6_ff),
      .in_rem    (rem6_ff),
      .in_low    (low6_ff),
      .in_den    (mden6_ff),
      .out_valid (dv_valid),
      .out_tag   (dv_tag),
      .out_quot  (dv_quot)
   );

   logic signed [31:0] t_in;
   always_comb begin
      if (!dv_tag.hit)
         t_in = '0;
      else if (dv_tag.sat)
         t_in = dv_tag.neg ? 32'sh80000000 : 32'sh7fffffff;
      else if (dv_tag.neg)
         t_in = -$signed({1'b0, dv_quot});
      else
         t_in = $signed({1'b0, dv_quot});
   end

   logic               rsp_valid_ff;
   logic signed [31:0] dist_ff;
   logic [1:0]         side_ff;
   logic               hit_ff;
   logic signed [31:0] t_ff;
   logic signed [31:0] px_ff;
   logic signed [31:0] py_ff;
   logic signed [31:0] pz_ff;

   always_ff @(posedge clock) begin
      dist_ff <= dv_tag.distance;
      side_ff <= dv_tag.side;
      hit_ff  <= dv_tag.hit;
      t_ff    <= t_in;
      px_ff   <= dv_tag.proj_x;
      py_ff   <= dv_tag.proj_y;
      pz_ff   <= dv_tag.proj_z;
      if (reset)
         rsp_valid_ff <= 1'b0;
      else
         rsp_valid_ff <= dv_valid;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_signed_distance = dist_ff;
   assign rsp_side            = side_ff;
   assign rsp_hit             = hit_ff;
   assign rsp_hit_t           = t_ff;
   assign rsp_proj_x          = px_ff;
   assign rsp_proj_y          = py_ff;
   assign rsp_proj_z          = pz_ff;

   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, LATENCY))
      else $error("result without a transaction at the expected latency");

   a_no_hit_t: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_hit |-> rsp_hit_t == '0)
      else $error("ray parameter nonzero without a hit");

   a_front_sign: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_side == SIDE_FRONT |-> !rsp_signed_distance[31])
      else $error("front side with negative distance");

   a_back_sign: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_side == SIDE_BACK |-> rsp_signed_distance[31])
      else $error("back side with nonnegative distance");

endmodule
